>>> rtl/fixed_slot_free_list_pool_top_assert.svh
// Assertion macros for the free list pool checker.
`ifndef FIXED_SLOT_FREE_LIST_POOL_TOP_ASSERT_SVH
`define FIXED_SLOT_FREE_LIST_POOL_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FSLP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fslp assertion failed");

// Next-cycle implication, disabled during reset.
`define FSLP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fslp assertion failed");

// Property of the cycle after reset.
`define FSLP_ASSERT_RST(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("fslp reset assertion failed");

`endif

>>> rtl/fslp_pkg.sv
`default_nettype none

package fslp_pkg;

   localparam int unsigned FSLP_CAPACITY  = 256;
   localparam int unsigned DATA_WIDTH     = 32;
   localparam int unsigned CFG_WIDTH      = 17;
   localparam int unsigned DIVISOR_WIDTH  = 18;
   localparam int unsigned OPCODE_WIDTH   = 3;
   localparam int unsigned STATUS_WIDTH   = 2;
   localparam int unsigned PADDR_WIDTH    = 3;

   localparam logic [CFG_WIDTH-1:0] STRIDE_RESET = CFG_WIDTH'(4);

   localparam logic [OPCODE_WIDTH-1:0] OP_CREATE  = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_DESTROY = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_COUNT   = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_ALLOC   = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_FREE    = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_INVALID  = 2'd3;

   localparam logic REG_STRIDE = 1'b0;

   typedef struct packed {
      logic                     start;
      logic [DATA_WIDTH-1:0]    dividend;
      logic [DIVISOR_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DATA_WIDTH-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> rtl/fslp_ram.sv
`default_nettype none

module fslp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/fslp_div.sv
`default_nettype none

module fslp_div
   import fslp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   localparam int unsigned CW = $clog2(DATA_WIDTH);

   logic                     busy_ff;
   logic                     done_ff;
   logic [CW-1:0]            cnt_ff;
   logic [DIVISOR_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0]    quo_ff;
   logic [DIVISOR_WIDTH-1:0] div_ff;

   logic [DIVISOR_WIDTH:0]   trial;
   logic [DIVISOR_WIDTH:0]   diff;
   logic                     fits;

   assign trial = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign fits  = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= req.dividend;
            div_ff  <= req.divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
            quo_ff <= {quo_ff[DATA_WIDTH-2:0], fits};
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(DATA_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/fixed_slot_free_list_pool_top.sv
// channel  direction  fields
// req      in         opcode, address, byte_size
// rsp      out        result_value, status
// csr      in/out     element_stride at byte address 0
//
// Count, alloc, free: IDLE, then FINISH, then back to IDLE for the next word; alloc reads the stack RAM at most once.
// Create: 32-step divider, then one RAM push per cycle.
// Destroy: one RAM read, at most one write a cycle.
// Reset clears depth and sets stride to 4; stack RAM is not cleared.
// A stalled rsp word does not block accepting the next req word.
`default_nettype none

module fixed_slot_free_list_pool_top
   import fslp_pkg::*;
#(
   parameter int unsigned CAPACITY = FSLP_CAPACITY
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [OPCODE_WIDTH-1:0] req_opcode,
   input  wire logic [DATA_WIDTH-1:0]   req_address,
   input  wire logic [DATA_WIDTH-1:0]   req_byte_size,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [DATA_WIDTH-1:0]        rsp_result_value,
   output logic [STATUS_WIDTH-1:0]      rsp_status,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [PADDR_WIDTH-1:0]  paddr,
   input  wire logic [DATA_WIDTH-1:0]   pwdata,
   output logic [DATA_WIDTH-1:0]        prdata,
   output logic                         pready
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned DW = $clog2(CAPACITY + 1);
   localparam logic [DW-1:0] CAP_D = DW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PUSH,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                state_ff;
   logic [CFG_WIDTH-1:0]     stride_ff;
   logic [DW-1:0]            depth_ff;
   logic [DW-1:0]            push_left_ff;
   logic [DATA_WIDTH-1:0]    push_addr_ff;
   logic [DW-1:0]            scan_ff;
   logic [DW-1:0]            wptr_ff;
   logic                     chk_vld_ff;
   logic [DATA_WIDTH-1:0]    lo_ff;
   logic [DATA_WIDTH:0]      hi_ff;
   logic [DATA_WIDTH-1:0]    res_value_ff;
   logic [STATUS_WIDTH-1:0]  res_status_ff;
   logic                     alloc_hit_ff;
   logic                     rsp_valid_ff;
   logic [DATA_WIDTH-1:0]    rsp_value_ff;
   logic [STATUS_WIDTH-1:0]  rsp_status_ff;

   logic                     accept;
   logic                     cfg_write;
   logic [DIVISOR_WIDTH-1:0] stride_rnd;
   logic [DIVISOR_WIDTH-1:0] stride_eff;
   logic [1:0]               offset;
   logic [DATA_WIDTH-1:0]    aligned;
   logic [DATA_WIDTH-1:0]    dividend;
   logic [DW-1:0]            room;
   logic                     keep;
   logic                     scan_rd;
   logic                     out_load;

   logic                     ram_wr_en;
   logic [AW-1:0]            ram_wr_addr;
   logic [DATA_WIDTH-1:0]    ram_wr_data;
   logic                     ram_rd_en;
   logic [AW-1:0]            ram_rd_addr;
   logic [DATA_WIDTH-1:0]    ram_rd_data;

   div_req_type              div_req;
   div_rsp_type              div_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_STRIDE) ? DATA_WIDTH'(stride_ff) : '0;

   assign stride_rnd = (DIVISOR_WIDTH'(stride_ff) + DIVISOR_WIDTH'(3)) & ~DIVISOR_WIDTH'(3);
   assign stride_eff = (stride_rnd == '0) ? DIVISOR_WIDTH'(4) : stride_rnd;
   assign offset     = 2'(~req_address[1:0] + 2'd1);
   assign aligned    = (req_address + DATA_WIDTH'(3)) & ~DATA_WIDTH'(3);
   assign dividend   = (req_byte_size < DATA_WIDTH'(offset)) ? '0
                                                             : req_byte_size - DATA_WIDTH'(offset);
   assign room       = CAP_D - depth_ff;

   assign div_req.start    = accept && (req_opcode == OP_CREATE);
   assign div_req.dividend = dividend;
   assign div_req.divisor  = stride_eff;

   assign keep    = !(({1'b0, ram_rd_data} >= {1'b0, lo_ff}) && ({1'b0, ram_rd_data} < hi_ff));
   assign scan_rd = (state_ff == ST_SCAN) && (scan_ff != depth_ff);
   assign out_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = depth_ff[AW-1:0];
      ram_wr_data = req_address;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(depth_ff - DW'(1));
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_FREE) && (depth_ff != CAP_D)) begin
               ram_wr_en = 1'b1;
            end
            if (accept && (req_opcode == OP_ALLOC) && (depth_ff != '0)) begin
               ram_rd_en = 1'b1;
            end
         end
         ST_PUSH: begin
            ram_wr_en   = (push_left_ff != '0);
            ram_wr_data = push_addr_ff;
         end
         ST_SCAN: begin
            ram_rd_en   = scan_rd;
            ram_rd_addr = scan_ff[AW-1:0];
            ram_wr_en   = chk_vld_ff && keep;
            ram_wr_addr = wptr_ff[AW-1:0];
            ram_wr_data = ram_rd_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stride_ff    <= STRIDE_RESET;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         alloc_hit_ff <= 1'b0;
      end else begin
         if (cfg_write && (paddr[2] == REG_STRIDE)) begin
            stride_ff <= pwdata[CFG_WIDTH-1:0];
         end
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  alloc_hit_ff  <= 1'b0;
                  res_value_ff  <= '0;
                  res_status_ff <= STATUS_OK;
                  state_ff      <= ST_FINISH;
                  case (req_opcode)
                     OP_CREATE: begin
                        push_addr_ff <= aligned;
                        state_ff     <= ST_DIV;
                     end
                     OP_DESTROY: begin
                        lo_ff      <= req_address;
                        hi_ff      <= {1'b0, req_address} + {1'b0, req_byte_size};
                        scan_ff    <= '0;
                        wptr_ff    <= '0;
                        chk_vld_ff <= 1'b0;
                        state_ff   <= ST_SCAN;
                     end
                     OP_COUNT: begin
                        res_value_ff <= DATA_WIDTH'(depth_ff);
                     end
                     OP_ALLOC: begin
                        if (depth_ff == '0) begin
                           res_status_ff <= STATUS_EMPTY;
                        end else begin
                           depth_ff     <= depth_ff - DW'(1);
                           alloc_hit_ff <= 1'b1;
                        end
                     end
                     OP_FREE: begin
                        if (depth_ff == CAP_D) begin
                           res_status_ff <= STATUS_OVERFLOW;
                        end else begin
                           depth_ff <= depth_ff + DW'(1);
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  res_value_ff <= div_rsp.quotient;
                  state_ff     <= ST_PUSH;
                  if (div_rsp.quotient > DATA_WIDTH'(room)) begin
                     push_left_ff  <= room;
                     res_status_ff <= STATUS_OVERFLOW;
                  end else begin
                     push_left_ff <= div_rsp.quotient[DW-1:0];
                  end
               end
            end
            ST_PUSH: begin
               if (push_left_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  depth_ff     <= depth_ff + DW'(1);
                  push_addr_ff <= push_addr_ff + DATA_WIDTH'(stride_eff);
                  push_left_ff <= push_left_ff - DW'(1);
               end
            end
            ST_SCAN: begin
               chk_vld_ff <= scan_rd;
               if (scan_rd) begin
                  scan_ff <= scan_ff + DW'(1);
               end
               if (chk_vld_ff && keep) begin
                  wptr_ff <= wptr_ff + DW'(1);
               end
               if ((scan_ff == depth_ff) && !chk_vld_ff) begin
                  depth_ff <= wptr_ff;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_load) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= alloc_hit_ff ? ram_rd_data : res_value_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   fslp_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fslp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule

`default_nettype wire

>>> rtl/fslp_checker.sv
`default_nettype none

`include "fixed_slot_free_list_pool_top_assert.svh"

module fslp_checker
   import fslp_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [DATA_WIDTH-1:0]   rsp_result_value,
   input wire logic [STATUS_WIDTH-1:0] rsp_status
);

   `FSLP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status))
   `FSLP_ASSERT_IMP(a_status_code, rsp_valid, rsp_status != STATUS_INVALID)
   `FSLP_ASSERT_IMP(a_empty_zero, rsp_valid && (rsp_status == STATUS_EMPTY), rsp_result_value == '0)
   `FSLP_ASSERT_RST(a_reset_idle, !rsp_valid)

endmodule

bind fixed_slot_free_list_pool_top fslp_checker u_fslp_checker (.*);

`default_nettype wire

>>> verif/tb_fixed_slot_free_list_pool_top.sv
`timescale 1ns / 100ps

module tb_fixed_slot_free_list_pool_top;
   import fslp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned PHASE_WORDS  = 203;
   localparam int unsigned DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic [DATA_WIDTH-1:0]   address;
      logic [DATA_WIDTH-1:0]   byte_size;
   } pool_cmd_type;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic [DATA_WIDTH-1:0]   value;
      logic [STATUS_WIDTH-1:0] status;
   } pool_reply_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [OPCODE_WIDTH-1:0] req_opcode = '0;
   logic [DATA_WIDTH-1:0]   req_address = '0;
   logic [DATA_WIDTH-1:0]   req_byte_size = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [DATA_WIDTH-1:0]   rsp_result_value;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [PADDR_WIDTH-1:0]  paddr = '0;
   logic [DATA_WIDTH-1:0]   pwdata = '0;
   logic [DATA_WIDTH-1:0]   prdata;
   logic                    pready;

   fixed_slot_free_list_pool_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_address      (req_address),
      .req_byte_size    (req_byte_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // shadow of the pool
   logic [DATA_WIDTH-1:0] free_slots [FSLP_CAPACITY];
   int unsigned           free_count;
   logic [CFG_WIDTH-1:0]  slot_stride;

   pool_cmd_type   cmd_q [$];
   pool_reply_type reply_q [$];
   pool_cmd_type   cur_cmd;

   logic                  calm = 1'b0;
   logic [DATA_WIDTH-1:0] gen_base = '0;
   int unsigned           mismatches = 0;
   int unsigned           cycle_count = 0;
   int unsigned           words_queued = 0;
   int unsigned           words_sent = 0;
   int unsigned           words_checked = 0;
   int unsigned           overflow_seen = 0;
   int unsigned           empty_seen = 0;
   int unsigned           stride_writes = 0;
   int unsigned           op_seen [8];

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count, reply_q.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] %s", $realtime, msg);
   endtask

   // next result of the pool for one accepted word
   task automatic advance_pool(input pool_cmd_type cmd);
      pool_reply_type        r;
      logic [DATA_WIDTH-1:0] aligned, offset, unit, count, room, n, i;
      logic [DATA_WIDTH:0]   lo, hi, e;
      int unsigned           w;
      r.opcode = cmd.opcode;
      r.value  = '0;
      r.status = STATUS_OK;
      case (cmd.opcode)
         OP_CREATE: begin
            aligned = (cmd.address + 32'd3) & ~32'd3;
            offset  = aligned - cmd.address;
            unit    = ({15'd0, slot_stride} + 32'd3) & ~32'd3;
            if (unit == '0)
               unit = 32'd4;
            count = (cmd.byte_size < offset) ? '0 : (cmd.byte_size - offset) / unit;
            room  = FSLP_CAPACITY - free_count;
            n     = count;
            if (n > room) begin
               n        = room;
               r.status = STATUS_OVERFLOW;
            end
            for (i = 0; i < n; i++) begin
               free_slots[free_count] = aligned + i * unit;
               free_count++;
            end
            r.value = count;
         end
         OP_DESTROY: begin
            lo = {1'b0, cmd.address};
            hi = lo + {1'b0, cmd.byte_size};
            w  = 0;
            for (int unsigned k = 0; k < free_count; k++) begin
               e = {1'b0, free_slots[k]};
               if (!(e >= lo && e < hi)) begin
                  free_slots[w] = free_slots[k];
                  w++;
               end
            end
            free_count = w;
         end
         OP_COUNT: r.value = free_count;
         OP_ALLOC: begin
            if (free_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               free_count--;
               r.value = free_slots[free_count];
            end
         end
         OP_FREE: begin
            if (free_count >= FSLP_CAPACITY) begin
               r.status = STATUS_OVERFLOW;
            end else begin
               free_slots[free_count] = cmd.address;
               free_count++;
            end
         end
         default: ;
      endcase
      if (r.status == STATUS_OVERFLOW)
         overflow_seen++;
      if (r.status == STATUS_EMPTY)
         empty_seen++;
      reply_q.push_back(r);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_pool(cur_cmd);
            op_seen[cur_cmd.opcode]++;
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
               cur_cmd = cmd_q.pop_front();
               req_opcode    <= cur_cmd.opcode;
               req_address   <= cur_cmd.address;
               req_byte_size <= cur_cmd.byte_size;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= calm || ($urandom_range(99) >= 26);
   end

   // monitor
   always @(posedge clock) begin
      pool_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (reply_q.size() == 0) begin
            note_mismatch($sformatf("word with nothing expected: value %h status %0d",
                                    rsp_result_value, rsp_status));
         end else begin
            want = reply_q.pop_front();
            if (rsp_result_value !== want.value)
               note_mismatch($sformatf("op %0d value: expected %h got %h",
                                       want.opcode, want.value, rsp_result_value));
            if (rsp_status !== want.status)
               note_mismatch($sformatf("op %0d status: expected %0d got %0d",
                                       want.opcode, want.status, rsp_status));
         end
      end
   end

   task automatic queue_word(input logic [OPCODE_WIDTH-1:0] op,
                             input logic [DATA_WIDTH-1:0] addr,
                             input logic [DATA_WIDTH-1:0] size);
      pool_cmd_type c;
      c.opcode    = op;
      c.address   = addr;
      c.byte_size = size;
      cmd_q.push_back(c);
      words_queued++;
   endtask

   task automatic queue_random_word(input logic [DATA_WIDTH-1:0] unit);
      pool_cmd_type c;
      int unsigned  pick;
      pick        = $urandom_range(99);
      c.address   = $urandom();
      c.byte_size = $urandom();
      if (pick < 10) begin
         c.opcode = OP_CREATE;
         if ($urandom_range(9) != 0)
            c.byte_size = $urandom_range(0, 24) * unit + $urandom_range(0, 7);
         if ($urandom_range(7) == 0)
            c.address = 32'hFFFF_FFF0 | $urandom_range(0, 15);
         gen_base = (c.address + 32'd3) & ~32'd3;
      end else if (pick < 15) begin
         c.opcode = OP_DESTROY;
         case ($urandom_range(9))
            0: c.byte_size = '0;
            1, 2: ;
            default: begin
               c.address   = gen_base + $urandom_range(0, 8) * unit;
               c.byte_size = $urandom_range(1, 8) * unit;
            end
         endcase
      end else if (pick < 25) begin
         c.opcode = OP_COUNT;
      end else if (pick < 63) begin
         c.opcode = OP_ALLOC;
      end else if (pick < 95) begin
         c.opcode = OP_FREE;
         if ($urandom_range(9) < 7)
            c.address = gen_base + $urandom_range(0, 31) * unit;
      end else begin
         c.opcode = OPCODE_WIDTH'($urandom_range(5, 7));
      end
      cmd_q.push_back(c);
      words_queued++;
   endtask

   // every queued word has come back, so nothing is in flight
   task automatic wait_pool_idle();
      while (words_checked < words_queued)
         @(posedge clock);
   endtask

   task automatic write_stride(input logic [CFG_WIDTH-1:0] val);
      logic [DATA_WIDTH-1:0] wdata;
      wdata = {{(DATA_WIDTH-CFG_WIDTH){1'b0}}, val};
      if ($urandom_range(3) == 0)
         wdata = wdata | ($urandom() & 32'hFFFE_0000);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_WIDTH'({REG_STRIDE, 2'b00});
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      slot_stride  = wdata[CFG_WIDTH-1:0];
      stride_writes++;
   endtask

   initial begin
      logic [CFG_WIDTH-1:0]  stride_plan [8];
      logic [DATA_WIDTH-1:0] unit;
      free_count  = 0;
      slot_stride = STRIDE_RESET;
      foreach (op_seen[k])
         op_seen[k] = 0;
      stride_plan = '{17'h00000, 17'h00001, 17'h1FFFF, 17'h10000,
                      17'h00006, 17'h0000C, 17'h00000, 17'h00004};
      stride_plan[6] = CFG_WIDTH'($urandom_range(1, 300));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed pass, reset stride
      queue_word(OP_ALLOC,   32'h0,          32'h0);
      queue_word(OP_COUNT,   32'h0,          32'h0);
      queue_word(OP_CREATE,  32'h0000_1001,  32'd3);
      queue_word(OP_CREATE,  32'h0000_1001,  32'd2);
      queue_word(OP_CREATE,  32'h0,          32'd8);
      queue_word(OP_ALLOC,   32'h0,          32'h0);
      queue_word(OP_ALLOC,   32'h0,          32'h0);
      queue_word(OP_ALLOC,   32'h0,          32'h0);
      queue_word(OP_FREE,    32'hFFFF_FFFF,  32'hFFFF_FFFF);
      queue_word(OP_FREE,    32'h0,          32'h0);
      queue_word(OP_CREATE,  32'hFFFF_FFFD,  32'hFFFF_FFFF);
      queue_word(OP_COUNT,   32'h0,          32'h0);
      queue_word(OP_FREE,    32'h1234_5678,  32'h0);
      queue_word(OP_CREATE,  32'h0000_0100,  32'd16);
      queue_word(OP_DESTROY, 32'h0,          32'h0);
      queue_word(OP_DESTROY, 32'h0000_0010,  32'h0000_0020);
      queue_word(OP_COUNT,   32'h0,          32'h0);
      queue_word(OP_DESTROY, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
      queue_word(OP_ALLOC,   32'h0,          32'h0);
      queue_word(3'd5,       32'hA5A5_A5A5,  32'h5A5A_5A5A);
      queue_word(3'd6,       32'hFFFF_FFFF,  32'hFFFF_FFFF);
      queue_word(3'd7,       32'h0,          32'h0);
      queue_word(OP_DESTROY, 32'h0,          32'hFFFF_FFFF);
      queue_word(OP_COUNT,   32'h0,          32'h0);
      queue_word(OP_ALLOC,   32'h0,          32'h0);
      wait_pool_idle();

      foreach (stride_plan[p]) begin
         write_stride(stride_plan[p]);
         unit = ({15'd0, slot_stride} + 32'd3) & ~32'd3;
         if (unit == '0)
            unit = 32'd4;
         calm = (p == 3);
         for (int unsigned k = 0; k < PHASE_WORDS; k++)
            queue_random_word(unit);
         wait_pool_idle();
      end
      calm = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d words, checked %0d, %0d stride writes incl. 0, 1 and 17'h1FFFF",
               words_sent, words_checked, stride_writes);
      $display("creates %0d destroys %0d allocs %0d frees %0d, %0d overflows %0d empties",
               op_seen[OP_CREATE], op_seen[OP_DESTROY], op_seen[OP_ALLOC], op_seen[OP_FREE],
               overflow_seen, empty_seen);
      if (mismatches == 0 && reply_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d words still expected", mismatches, reply_q.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/fslp_pkg.sv
rtl/fslp_ram.sv
rtl/fslp_div.sv
rtl/fixed_slot_free_list_pool_top.sv
rtl/fslp_checker.sv
verif/tb_fixed_slot_free_list_pool_top.sv
